@@ rtl/great_circle_distance_macros.svh @@
// Assertion macros for the great_circle_distance block.
// Used by the checker; expects i_clk and i_rst_n in scope.
`ifndef GREAT_CIRCLE_DISTANCE_MACROS_SVH
`define GREAT_CIRCLE_DISTANCE_MACROS_SVH

// Clocked assertion, off while reset is held.
`define GCD_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Clocked assertion that also checks through reset.
`define GCD_ASSERT_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

@@ rtl/gcd_pkg.sv @@
// Shared types, constants and CORDIC/root step functions for great_circle_distance.
// No dependencies.
`default_nettype none

package gcd_pkg;

    localparam int GCD_CORDIC_ITERS = 24;
    localparam int GCD_QUEUE_DEPTH  = 4;
    localparam int SQ_STAGES        = 31;   // one root bit per stage, Q60 -> Q30
    localparam int ANG_W            = 34;   // angle width before reduction
    localparam int CW               = 34;   // CORDIC lane width

    localparam logic [2:0]              RADIUS_ADDR    = 3'd0;  // byte address of radius reg

    localparam logic signed [ANG_W-1:0] HALF_CIRCLE    = 34'sd3600000000;
    localparam logic signed [ANG_W-1:0] FULL_CIRCLE    = 34'sd7200000000;
    localparam logic signed [ANG_W-1:0] QUARTER_CIRCLE = 34'sd1800000000;
    localparam logic [31:0]             UNIT_TO_RAD    = 32'd4024455254;
    localparam logic signed [CW-1:0]    INV_GAIN       = 34'sd652032874;
    localparam logic [30:0]             ONE_Q30        = 31'd1073741824;
    localparam logic [22:0]             RADIUS_RESET   = 23'd6371009;

    // reduced angles of one beat: lanes dlat, dlon, 2*slat, 2*elat
    typedef struct packed {
        logic signed [31:0] z_dlat;
        logic signed [31:0] z_dlon;
        logic signed [31:0] z_slat;
        logic signed [31:0] z_elat;
        logic               nc_slat;
        logic               nc_elat;
    } t_angles;

    localparam int ANGLES_W = $bits(t_angles);

    typedef struct packed {
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic signed [CW-1:0] z;
    } t_rot;

    typedef struct packed {
        logic [30:0] h;
        logic [32:0] rem;
        logic [30:0] root;
    } t_sqrt;

    // atan(2^-i) in Q30
    function automatic logic signed [CW-1:0] atan_q30(input int unsigned i);
        logic signed [CW-1:0] v;
        case (i)
            0:  v = 34'sd843314857;
            1:  v = 34'sd497837829;
            2:  v = 34'sd263043837;
            3:  v = 34'sd133525159;
            4:  v = 34'sd67021687;
            5:  v = 34'sd33543516;
            6:  v = 34'sd16775851;
            7:  v = 34'sd8388437;
            8:  v = 34'sd4194283;
            9:  v = 34'sd2097149;
            10: v = 34'sd1048576;
            default: begin
                if (i <= 30) begin
                    v = 34'sd1 <<< (30 - i);
                end else if (i == 31) begin
                    v = 34'sd1;
                end else begin
                    v = '0;
                end
            end
        endcase
        return v;
    endfunction

    function automatic t_rot rot_seed(input logic signed [31:0] z);
        t_rot o;
        o.x = INV_GAIN;
        o.y = '0;
        o.z = CW'(z);
        return o;
    endfunction

    // rotation mode: drive z to zero
    function automatic t_rot cordic_rot_step(input t_rot v, input int unsigned i);
        t_rot o;
        logic signed [CW-1:0] x, y, z, dx, dy;
        x  = v.x;
        y  = v.y;
        z  = v.z;
        dx = y >>> i;
        dy = x >>> i;
        if (!z[CW-1]) begin
            o.x = x - dx;
            o.y = y + dy;
            o.z = z - atan_q30(i);
        end else begin
            o.x = x + dx;
            o.y = y - dy;
            o.z = z + atan_q30(i);
        end
        return o;
    endfunction

    // vectoring mode: drive y to zero, z collects the angle
    function automatic t_rot cordic_vec_step(input t_rot v, input int unsigned i);
        t_rot o;
        logic signed [CW-1:0] x, y, z, dx, dy;
        x  = v.x;
        y  = v.y;
        z  = v.z;
        dx = y >>> i;
        dy = x >>> i;
        if (!y[CW-1]) begin
            o.x = x + dx;
            o.y = y - dy;
            o.z = z + atan_q30(i);
        end else begin
            o.x = x - dx;
            o.y = y + dy;
            o.z = z - atan_q30(i);
        end
        return o;
    endfunction

    // one bit of floor sqrt of {h, 30'b0}
    function automatic t_sqrt sqrt_step(input t_sqrt s, input int unsigned j);
        t_sqrt       o;
        logic [61:0] v;
        logic [34:0] cur, trial;
        v     = {1'b0, s.h, 30'b0};
        cur   = {s.rem, v[61 - 2*j -: 2]};
        trial = {2'b00, s.root, 2'b01};
        o.h   = s.h;
        if (cur >= trial) begin
            o.rem  = 33'(cur - trial);
            o.root = {s.root[29:0], 1'b1};
        end else begin
            o.rem  = cur[32:0];
            o.root = {s.root[29:0], 1'b0};
        end
        return o;
    endfunction

endpackage

`default_nettype wire

@@ rtl/great_circle_distance.sv @@
// Top level of the great_circle_distance block: config registers, front, queue, back.
// Depends on gcd_pkg, gcd_front, gcd_fifo, gcd_back.
//
// Usage
//  - Input channel is queue-like: present a point pair and raise push; the beat
//    is taken on a clock edge with push high and full low.
//  - Result channel: while empty is low, o_distance_cm holds the oldest distance
//    (centimeters); it is taken on a clock edge with pop high.
//  - One pair per cycle sustained while pop is high. The path: 3 front stages,
//    the queue, two CORDIC chains of CORDIC_ITERATIONS stages each, 31 square
//    root stages and 6 arithmetic stages.
//  - If pop is held low the back pipe freezes with the result on the ports; the
//    queue and then the front fill up, and full rises after a few more beats.
//  - APB port: register 0 at byte address 0 is the radius in meters (23 bits).
//    Write it only while no beat is in flight; reads return the stored value.
//  - Synchronous active-low reset empties the pipe and queue and restores the
//    radius to its default.
`default_nettype none

module great_circle_distance #(
    parameter int CORDIC_ITERATIONS = gcd_pkg::GCD_CORDIC_ITERS
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // input beats
    input  logic               push,
    output logic               full,
    input  logic signed [30:0] i_start_lat,
    input  logic signed [31:0] i_start_lon,
    input  logic signed [30:0] i_end_lat,
    input  logic signed [31:0] i_end_lon,
    // result beats
    output logic               empty,
    input  logic               pop,
    output logic [31:0]        o_distance_cm,
    // configuration
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);
    import gcd_pkg::*;

    localparam logic REG_RADIUS = 1'b0;   // word index of the radius register

    logic [22:0]      r_radius;
    logic [30:0]      r_radius_x200;
    logic             q_push, q_full, q_pop, q_empty;
    t_angles          q_wdata, q_rdata;
    logic [ANGLES_W-1:0] q_rbits;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_RADIUS) ? {9'b0, r_radius} : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radius <= RADIUS_RESET;
        end else if (psel && penable && pwrite && (paddr[2] == REG_RADIUS)) begin
            r_radius <= pwdata[22:0];
        end
    end

    // 200 * R fits in 31 bits; the two factors of 100 and 2 in the formula
    always_ff @(posedge i_clk) begin
        r_radius_x200 <= 31'(r_radius) * 31'd200;
    end

    gcd_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .o_full      (full),
        .i_start_lat (i_start_lat),
        .i_start_lon (i_start_lon),
        .i_end_lat   (i_end_lat),
        .i_end_lon   (i_end_lon),
        .o_q_push    (q_push),
        .o_q_data    (q_wdata),
        .i_q_full    (q_full)
    );

    gcd_fifo #(
        .WIDTH (ANGLES_W),
        .DEPTH (GCD_QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_wdata),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_data  (q_rbits),
        .o_empty (q_empty)
    );

    assign q_rdata = t_angles'(q_rbits);

    gcd_back #(
        .ITERS (CORDIC_ITERATIONS)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_empty     (q_empty),
        .o_q_pop       (q_pop),
        .i_q_data      (q_rdata),
        .i_radius_x200 (r_radius_x200),
        .i_pop         (pop),
        .o_empty       (empty),
        .o_distance_cm (o_distance_cm)
    );

endmodule

`default_nettype wire

@@ rtl/gcd_fifo.sv @@
// Small register queue between the front and back parts.
// No dependencies.
`default_nettype none

module gcd_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wp, r_rp;
    logic [CNT_W-1:0] r_cnt;
    logic             do_push, do_pop;

    assign o_full  = (r_cnt == CNT_W'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rp];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wp <= (r_wp == PTR_W'(DEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (do_pop) begin
                r_rp <= (r_rp == PTR_W'(DEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

@@ rtl/gcd_front.sv @@
// Front part: takes point pairs, forms the four angles, reduces them to Q30 radians.
// Depends on gcd_pkg.
`default_nettype none

module gcd_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    output logic               o_full,
    input  logic signed [30:0] i_start_lat,
    input  logic signed [31:0] i_start_lon,
    input  logic signed [30:0] i_end_lat,
    input  logic signed [31:0] i_end_lon,
    output logic               o_q_push,
    output gcd_pkg::t_angles   o_q_data,
    input  logic               i_q_full
);
    import gcd_pkg::*;

    logic                    fe;
    logic                    r_v1, r_v2, r_v3;
    logic signed [ANG_W-1:0] r_a1 [4];
    logic [30:0]             r_mag2 [4];
    logic [3:0]              r_neg2, r_nc2;
    logic signed [31:0]      r_z3 [4];
    logic [1:0]              r_nc3;
    logic [30:0]             n_mag [4];
    logic [3:0]              n_neg, n_nc;
    logic signed [31:0]      n_z [4];

    assign fe       = !r_v3 || !i_q_full;
    assign o_full   = !fe;
    assign o_q_push = r_v3;

    always_comb begin
        o_q_data.z_dlat  = r_z3[0];
        o_q_data.z_dlon  = r_z3[1];
        o_q_data.z_slat  = r_z3[2];
        o_q_data.z_elat  = r_z3[3];
        o_q_data.nc_slat = r_nc3[0];
        o_q_data.nc_elat = r_nc3[1];
    end

    // wrap into a half turn, fold into a quarter turn
    always_comb begin
        logic signed [ANG_W-1:0] w, r, ab;
        for (int k = 0; k < 4; k++) begin
            if (r_a1[k] < -HALF_CIRCLE) begin
                w = r_a1[k] + FULL_CIRCLE;
            end else if (r_a1[k] >= HALF_CIRCLE) begin
                w = r_a1[k] - FULL_CIRCLE;
            end else begin
                w = r_a1[k];
            end
            if (w > QUARTER_CIRCLE) begin
                r       = HALF_CIRCLE - w;
                n_nc[k] = 1'b1;
            end else if (w < -QUARTER_CIRCLE) begin
                r       = -HALF_CIRCLE - w;
                n_nc[k] = 1'b1;
            end else begin
                r       = w;
                n_nc[k] = 1'b0;
            end
            n_neg[k] = r[ANG_W-1];
            ab       = n_neg[k] ? -r : r;
            n_mag[k] = ab[30:0];
        end
    end

    // scale to Q30 radians, round half up on the magnitude
    always_comb begin
        logic [63:0] p;
        logic [31:0] m;
        for (int k = 0; k < 4; k++) begin
            p      = {33'b0, r_mag2[k]} * {32'b0, UNIT_TO_RAD};
            p      = p + 64'h0000_0000_8000_0000;
            m      = {1'b0, p[62:32]};
            n_z[k] = r_neg2[k] ? -$signed(m) : $signed(m);
        end
    end

    always_ff @(posedge i_clk) begin
        if (fe) begin
            r_a1[0] <= ANG_W'(i_end_lat) - ANG_W'(i_start_lat);
            r_a1[1] <= ANG_W'(i_end_lon) - ANG_W'(i_start_lon);
            r_a1[2] <= ANG_W'(i_start_lat) <<< 1;
            r_a1[3] <= ANG_W'(i_end_lat) <<< 1;
            r_mag2  <= n_mag;
            r_neg2  <= n_neg;
            r_nc2   <= n_nc;
            r_z3    <= n_z;
            r_nc3   <= r_nc2[3:2];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else if (fe) begin
            r_v1 <= i_push;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

endmodule

`default_nettype wire

@@ rtl/gcd_back.sv @@
// Back part: sine/cosine CORDIC, haversine products, square roots,
// arcsine by vectoring CORDIC and radius scaling. Depends on gcd_pkg.
`default_nettype none

module gcd_back #(
    parameter int ITERS = gcd_pkg::GCD_CORDIC_ITERS
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_q_empty,
    output logic             o_q_pop,
    input  gcd_pkg::t_angles i_q_data,
    input  logic [30:0]      i_radius_x200,
    input  logic             i_pop,
    output logic             o_empty,
    output logic [31:0]      o_distance_cm
);
    import gcd_pkg::*;

    localparam int LAT = 2 * ITERS + SQ_STAGES + 6;

    logic           en;
    logic [LAT-1:0] r_vld;

    t_rot        r_rot [ITERS][4];
    logic [1:0]  r_rnc [ITERS];
    t_sqrt       r_sq  [SQ_STAGES][2];
    t_rot        r_vec [ITERS];

    logic signed [31:0] r_s1sq, r_cc, r_s2sq, r_s1sq_d, r_t;
    logic [30:0]        r_h, r_hc;
    logic [30:0]        r_zc;
    logic [61:0]        r_prod;
    logic [31:0]        r_out;

    // whole back pipe moves when the output slot is free or taken
    assign en            = !r_vld[LAT-1] || i_pop;
    assign o_q_pop       = en && !i_q_empty;
    assign o_empty       = !r_vld[LAT-1];
    assign o_distance_cm = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[LAT-2:0], !i_q_empty};
        end
    end

    // sine / cosine chain, four lanes
    for (genvar g = 0; g < ITERS; g++) begin : g_rot
        t_rot       n_in [4];
        logic [1:0] n_nc;
        if (g == 0) begin : g_seed
            always_comb begin
                n_in[0] = rot_seed(i_q_data.z_dlat);
                n_in[1] = rot_seed(i_q_data.z_dlon);
                n_in[2] = rot_seed(i_q_data.z_slat);
                n_in[3] = rot_seed(i_q_data.z_elat);
                n_nc    = {i_q_data.nc_elat, i_q_data.nc_slat};
            end
        end else begin : g_chain
            always_comb begin
                for (int k = 0; k < 4; k++) begin
                    n_in[k] = r_rot[g-1][k];
                end
                n_nc = r_rnc[g-1];
            end
        end
        always_ff @(posedge i_clk) begin
            if (en) begin
                for (int k = 0; k < 4; k++) begin
                    r_rot[g][k] <= cordic_rot_step(n_in[k], g);
                end
                r_rnc[g] <= n_nc;
            end
        end
    end

    // haversine: h = s1^2 + c1*c2*s2^2, three stages
    logic signed [CW-1:0] c1_full, c2_full;
    logic signed [31:0]   s1, s2, c1, c2;
    logic signed [63:0]   m_s1, m_s2, m_cc, m_t;
    logic signed [32:0]   h_sum;
    logic [30:0]          n_h;

    always_comb begin
        s1      = r_rot[ITERS-1][0].y[31:0];
        s2      = r_rot[ITERS-1][1].y[31:0];
        c1_full = r_rnc[ITERS-1][0] ? -r_rot[ITERS-1][2].x : r_rot[ITERS-1][2].x;
        c2_full = r_rnc[ITERS-1][1] ? -r_rot[ITERS-1][3].x : r_rot[ITERS-1][3].x;
        c1      = c1_full[31:0];
        c2      = c2_full[31:0];
        m_s1    = s1 * s1;
        m_s2    = s2 * s2;
        m_cc    = c1 * c2;
        m_t     = r_cc * r_s2sq;
        h_sum   = 33'(r_s1sq_d) + 33'(r_t);
        if (h_sum[32]) begin
            n_h = '0;
        end else if (h_sum > $signed({2'b00, ONE_Q30})) begin
            n_h = ONE_Q30;
        end else begin
            n_h = h_sum[30:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s1sq   <= m_s1[61:30];
            r_s2sq   <= m_s2[61:30];
            r_cc     <= m_cc[61:30];
            r_s1sq_d <= r_s1sq;
            r_t      <= m_t[61:30];
            r_h      <= n_h;
            r_hc     <= ONE_Q30 - n_h;
        end
    end

    // roots of h and 1-h, one bit per stage
    for (genvar j = 0; j < SQ_STAGES; j++) begin : g_sqrt
        t_sqrt n_in [2];
        if (j == 0) begin : g_seed
            always_comb begin
                n_in[0] = '{h: r_h,  rem: '0, root: '0};
                n_in[1] = '{h: r_hc, rem: '0, root: '0};
            end
        end else begin : g_chain
            always_comb begin
                n_in[0] = r_sq[j-1][0];
                n_in[1] = r_sq[j-1][1];
            end
        end
        always_ff @(posedge i_clk) begin
            if (en) begin
                r_sq[j][0] <= sqrt_step(n_in[0], j);
                r_sq[j][1] <= sqrt_step(n_in[1], j);
            end
        end
    end

    // atan2(sqrt(h), sqrt(1-h))
    for (genvar g = 0; g < ITERS; g++) begin : g_vec
        t_rot n_in;
        if (g == 0) begin : g_seed
            always_comb begin
                n_in.x = CW'(r_sq[SQ_STAGES-1][1].root);
                n_in.y = CW'(r_sq[SQ_STAGES-1][0].root);
                n_in.z = '0;
            end
        end else begin : g_chain
            assign n_in = r_vec[g-1];
        end
        always_ff @(posedge i_clk) begin
            if (en) begin
                r_vec[g] <= cordic_vec_step(n_in, g);
            end
        end
    end

    // clamp, scale by 200*R, round half up
    logic signed [CW-1:0] z_fin;
    logic [61:0]          n_round;

    always_comb begin
        z_fin   = r_vec[ITERS-1].z;
        n_round = r_prod + 62'd536870912;
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_zc   <= z_fin[CW-1] ? '0 : z_fin[30:0];
            r_prod <= {31'b0, r_zc} * {31'b0, i_radius_x200};
            r_out  <= n_round[61:30];
        end
    end

endmodule

`default_nettype wire

@@ rtl/gcd_checker.sv @@
// Port-level checks for great_circle_distance, bound to the top level.
// Depends on great_circle_distance_macros.svh.
`default_nettype none
`include "great_circle_distance_macros.svh"

module gcd_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        empty,
    input logic        pop,
    input logic [31:0] o_distance_cm,
    input logic        psel,
    input logic        penable,
    input logic        pwrite,
    input logic [2:0]  paddr,
    input logic [31:0] pwdata,
    input logic [31:0] prdata
);

    // reset drains the result side
    `GCD_ASSERT_RST(a_reset_empty, !i_rst_n |=> empty, "result shown right after reset")

    // a stalled result stays put
    `GCD_ASSERT(a_stall_hold, (!empty && !pop) |=> (!empty && $stable(o_distance_cm)), "stalled result changed")

    // radius written is read back next cycle
    `GCD_ASSERT(a_radius_readback, (psel && penable && pwrite && !paddr[2]) ##1 (psel && !pwrite && !paddr[2]) |-> (prdata[22:0] == $past(pwdata[22:0]) && prdata[31:23] == 9'd0), "radius readback mismatch")

endmodule

bind great_circle_distance gcd_checker u_checker (.*);

`default_nettype wire

@@ dv/gcd_distance_checker.sv @@
// Checker for great_circle_distance: predicts distances from accepted pairs and compares.
// Depends on gcd_pkg (iteration count and radius address only); no other files.
`timescale 1ns / 1ps
`default_nettype none

module gcd_distance_checker (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               push,
    input  wire logic               full,
    input  wire logic signed [30:0] i_start_lat,
    input  wire logic signed [31:0] i_start_lon,
    input  wire logic signed [30:0] i_end_lat,
    input  wire logic signed [31:0] i_end_lon,
    input  wire logic               empty,
    input  wire logic               pop,
    input  wire logic [31:0]        o_distance_cm,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [2:0]         paddr,
    input  wire logic [31:0]        pwdata,
    input  wire logic               pready,
    output int                      o_fail_count,
    output int                      o_pending,
    output int                      o_pairs_seen,
    output int                      o_dists_seen
);
    localparam int ITERS = gcd_pkg::GCD_CORDIC_ITERS;
    localparam logic [2:0] RADIUS_ADDR = gcd_pkg::RADIUS_ADDR;
    localparam longint FULL_U = 64'sd7200000000;
    localparam longint HALF_U = 64'sd3600000000;
    localparam longint QUART_U = 64'sd1800000000;
    localparam longint ONE = 64'sd1073741824;

    logic [22:0]  radius_m;
    logic [31:0]  dist_expected_q[$];
    longint       atan_tab[0:63];

    function automatic longint floor_shr(longint v, int s);
        if (s > 62) return (v < 0) ? -1 : 0;
        return v >>> s;
    endfunction

    function automatic longint atan_entry(int i);
        longint unsigned acc, term, e;
        acc = 0;
        if (i == 0) return 64'sd843314857;
        for (int k = 0; k < 64; k++) begin
            e = i * (2 * k + 1);
            if (e > 62) break;
            term = (64'd1 << (62 - e)) / (2 * k + 1);
            if (k & 1) acc -= term;
            else acc += term;
        end
        return longint'((acc + (64'd1 << 31)) >> 32);
    endfunction

    // a in 0.5e-7 degree; returns Q30 sine and cosine
    task automatic rotate_angle(input longint a, output longint s, output longint c);
        longint r, z, x, y, dx, dy;
        longint unsigned mag;
        bit neg_c, neg_a;
        neg_c = 0;
        r = a % FULL_U;
        if (r < 0) r += FULL_U;
        if (r >= HALF_U) r -= FULL_U;
        if (r > QUART_U) begin
            r = HALF_U - r; neg_c = 1;
        end else if (r < -QUART_U) begin
            r = -HALF_U - r; neg_c = 1;
        end
        neg_a = r < 0;
        mag = neg_a ? -r : r;
        mag = (mag * 64'd4024455254 + (64'd1 << 31)) >> 32;
        z = neg_a ? -longint'(mag) : longint'(mag);
        x = 64'sd652032874;
        y = 0;
        for (int i = 0; i < ITERS; i++) begin
            dx = floor_shr(y, i); dy = floor_shr(x, i);
            if (z >= 0) begin
                x -= dx; y += dy; z -= atan_tab[i];
            end else begin
                x += dx; y -= dy; z += atan_tab[i];
            end
        end
        s = y;
        c = neg_c ? -x : x;
    endtask

    function automatic longint floor_root(longint unsigned v);
        longint unsigned res, b;
        res = 0; b = 64'd1 << 62;
        while (b > v) b >>= 2;
        while (b != 0) begin
            if (v >= res + b) begin
                v -= res + b; res = (res >> 1) + b;
            end else res >>= 1;
            b >>= 2;
        end
        return longint'(res);
    endfunction

    task automatic predict_distance(input longint slat, slon, elat, elon,
                                    output logic [31:0] d_cm);
        longint s1, s2, c1, c2, junk, cc, h, x, y, z, dx, dy;
        longint unsigned d;
        rotate_angle(elat - slat, s1, junk);
        rotate_angle(elon - slon, s2, junk);
        rotate_angle(2 * slat, junk, c1);
        rotate_angle(2 * elat, junk, c2);
        cc = floor_shr(c1 * c2, 30);
        h = floor_shr(s1 * s1, 30) + floor_shr(cc * floor_shr(s2 * s2, 30), 30);
        if (h < 0) h = 0;
        if (h > ONE) h = ONE;
        y = floor_root(longint'(h) << 30);
        x = floor_root(longint'(ONE - h) << 30);
        z = 0;
        for (int i = 0; i < ITERS; i++) begin
            dx = floor_shr(y, i); dy = floor_shr(x, i);
            if (y >= 0) begin
                x += dx; y -= dy; z += atan_tab[i];
            end else begin
                x -= dx; y += dy; z -= atan_tab[i];
            end
        end
        if (z < 0) z = 0;
        d = (longint'(radius_m) * 200 * z + (64'd1 << 29)) >> 30;
        d_cm = d[31:0];
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] got, exp_v);
        $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, exp_v, $time);
        o_fail_count++;
    endtask

    initial begin
        for (int i = 0; i < 64; i++) atan_tab[i] = atan_entry(i);
        o_fail_count = 0;
        o_pending = 0;
        o_pairs_seen = 0;
        o_dists_seen = 0;
    end

    always @(posedge i_clk) begin
        logic [31:0] d;
        if (!i_rst_n) begin
            radius_m = 23'd6371009;
            dist_expected_q.delete();
        end else begin
            if (psel && penable && pwrite && pready && paddr == RADIUS_ADDR)
                radius_m = pwdata[22:0];
            if (push && !full) begin
                predict_distance(longint'(i_start_lat), longint'(i_start_lon),
                                 longint'(i_end_lat), longint'(i_end_lon), d);
                dist_expected_q = {dist_expected_q, d};
                o_pairs_seen++;
            end
            if (pop && !empty) begin
                o_dists_seen++;
                if (dist_expected_q.size() == 0)
                    report_mismatch("unexpected distance", o_distance_cm, 32'd0);
                else begin
                    d = dist_expected_q.pop_front();
                    if (o_distance_cm !== d)
                        report_mismatch("distance_cm", o_distance_cm, d);
                end
            end
        end
        o_pending = dist_expected_q.size();
    end
endmodule

`default_nettype wire

@@ dv/tb_great_circle_distance.sv @@
// Testbench top for great_circle_distance: clock, reset, APB writes, pair stimulus, verdict.
// Depends on gcd_pkg, great_circle_distance and gcd_distance_checker.
`timescale 1ns / 1ps
`default_nettype none

module tb_great_circle_distance;
    localparam logic [2:0] RADIUS_ADDR = gcd_pkg::RADIUS_ADDR;
    localparam int LATENCY = 2 * gcd_pkg::GCD_CORDIC_ITERS + 41;
    localparam int STALL_LIMIT = 20000;     // idle cycles with no beat moving
    localparam int RANDOM_PAIRS = 450;

    logic               i_clk, i_rst_n;
    logic               push, full, empty, pop;
    logic signed [30:0] start_lat, end_lat;
    logic signed [31:0] start_lon, end_lon;
    logic [31:0]        distance_cm;
    logic               psel, penable, pwrite, pready;
    logic [2:0]         paddr;
    logic [31:0]        pwdata, prdata;
    int                 fail_count, pending, pairs_seen, dists_seen;
    bit                 pop_random;     // pop side idles at random when set
    int                 idle_cycles;

    great_circle_distance dut (
        .i_clk, .i_rst_n, .push, .full,
        .i_start_lat(start_lat), .i_start_lon(start_lon),
        .i_end_lat(end_lat), .i_end_lon(end_lon),
        .empty, .pop, .o_distance_cm(distance_cm),
        .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
    );

    gcd_distance_checker chk (
        .i_clk, .i_rst_n, .push, .full,
        .i_start_lat(start_lat), .i_start_lon(start_lon),
        .i_end_lat(end_lat), .i_end_lon(end_lon),
        .empty, .pop, .o_distance_cm(distance_cm),
        .psel, .penable, .pwrite, .paddr, .pwdata, .pready,
        .o_fail_count(fail_count), .o_pending(pending),
        .o_pairs_seen(pairs_seen), .o_dists_seen(dists_seen)
    );

    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end

    // Gap lengths: mostly zero or short, now and then a long one.
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Pop side: random stalls while pop_random, else always ready.
    initial begin
        int g;
        pop = 0;
        forever begin
            @(negedge i_clk);
            if (!pop_random) pop <= 1;
            else begin
                g = gap_len();
                if (g == 0) pop <= 1;
                else begin
                    pop <= 0;
                    repeat (g - 1) @(negedge i_clk);
                end
            end
        end
    end

    // Watchdog: counts cycles where no beat moves on either side.
    always @(posedge i_clk) begin
        if (!i_rst_n || (push && !full) || (pop && !empty)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("Watchdog: no progress for %0d cycles", STALL_LIMIT);
            $display("Some tests failed");
            $finish;
        end
    end

    // Register write: setup then access phase, taken when pready is high.
    task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
        psel <= 1; penable <= 0; pwrite <= 1; paddr <= addr; pwdata <= data;
        @(negedge i_clk);
        penable <= 1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        psel <= 0; penable <= 0; pwrite <= 0;
    endtask

    // Block idle: wait for every distance back, then wait out a margin.
    task automatic drain();
        while (pending != 0) @(negedge i_clk);
        repeat (LATENCY + 4) @(negedge i_clk);
    endtask

    // Drive one pair; called at a falling edge, returns at a falling edge after acceptance.
    task automatic send_pair(input logic signed [30:0] slat, input logic signed [31:0] slon,
                             input logic signed [30:0] elat, input logic signed [31:0] elon,
                             input bit with_gaps);
        int g;
        g = with_gaps ? gap_len() : 0;
        if (g != 0) begin
            push <= 0;
            repeat (g) @(negedge i_clk);
        end
        push <= 1;
        start_lat <= slat; start_lon <= slon; end_lat <= elat; end_lon <= elon;
        do @(posedge i_clk); while (full);
        @(negedge i_clk);
    endtask

    function automatic logic signed [30:0] rand_lat();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) return 31'($urandom());              // any bit pattern, out of range too
        return 31'($signed($urandom_range(0, 1800000000)) - 900000000);
    endfunction

    function automatic logic signed [31:0] rand_lon();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) return 32'($urandom());
        return 32'($signed($urandom_range(0, 3600000000)) - 64'sd1800000000);
    endfunction

    initial begin
        logic [22:0] radii[4];
        logic signed [30:0] la;
        logic signed [31:0] lo;
        i_rst_n = 0;
        push = 0; pop_random = 0;
        start_lat = '0; start_lon = '0; end_lat = '0; end_lon = '0;
        psel = 0; penable = 0; pwrite = 0; paddr = RADIUS_ADDR; pwdata = '0;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1;
        @(negedge i_clk);

        // Directed, reset radius: identical points, antipodes, poles, dateline,
        // latitude and longitude extremes, raw out-of-range bit patterns.
        send_pair(0, 0, 0, 0, 0);
        send_pair(0, 0, 0, 1800000000, 0);
        send_pair(900000000, 0, -900000000, 0, 0);
        send_pair(900000000, 123, 900000000, -1800000000, 0);
        send_pair(0, 1799999999, 0, -1799999999, 0);
        send_pair(-900000000, -1800000000, 900000000, 1800000000, 0);
        send_pair(450000000, 0, -450000000, 1800000000, 0);
        send_pair(1, 0, 0, 1, 0);
        send_pair(31'h3fffffff, 32'h7fffffff, 31'h40000000, 32'h80000000, 0);
        send_pair(31'h40000000, 32'h80000000, 31'h3fffffff, 32'h7fffffff, 0);
        send_pair(31'h7fffffff, 32'hffffffff, 31'h55555555, 32'h55555555, 0);
        send_pair(31'h2aaaaaaa, 32'haaaaaaaa, 31'h00000000, 32'h00000000, 0);
        send_pair(1000000000, 0, -1000000000, 0, 0);      // out-of-range lats
        send_pair(515000000, -1200000, 407000000, -740000000, 0);
        push <= 0;
        drain();

        // Radius extremes and a few in between, random pairs under each.
        radii = '{23'd1, 23'h7fffff, 23'd6371000, 23'($urandom_range(2, 8388606))};
        apb_write(RADIUS_ADDR, 32'hffffffff);     // upper bits dropped: radius all ones
        send_pair(0, 0, 0, 1800000000, 0);
        send_pair(900000000, 0, -900000000, 0, 0);
        push <= 0;
        drain();
        apb_write(RADIUS_ADDR, 32'd0);            // zero radius gives zero distance
        send_pair(0, 0, 0, 1800000000, 0);
        send_pair(123456789, 5, -3, 987654321, 0);
        push <= 0;
        drain();

        for (int p = 0; p < 4; p++) begin
            apb_write(RADIUS_ADDR, {9'd0, radii[p]});
            pop_random = (p != 2);                // one phase with pop always high
            for (int n = 0; n < RANDOM_PAIRS / 4; n++) begin
                if ($urandom_range(0, 3) == 0) begin
                    // nearby points: small deltas exercise tiny angles
                    la = rand_lat(); lo = rand_lon();
                    send_pair(la, lo, la + 31'($signed($urandom_range(0, 2000)) - 1000),
                              lo + 32'($signed($urandom_range(0, 2000)) - 1000), p != 2);
                end else
                    send_pair(rand_lat(), rand_lon(), rand_lat(), rand_lon(), p != 1);
            end
            push <= 0;
            drain();
        end

        $display("Covered %0d point pairs and %0d distances over %0d radius settings",
                 pairs_seen, dists_seen, 7);
        if (fail_count == 0) $display("All tests passed");
        else $display("Some tests failed");
        $finish;
    end
endmodule

`default_nettype wire

@@ sim.f @@
+incdir+rtl
rtl/gcd_pkg.sv
rtl/gcd_fifo.sv
rtl/gcd_front.sv
rtl/gcd_back.sv
rtl/great_circle_distance.sv
rtl/gcd_checker.sv
dv/gcd_distance_checker.sv
dv/tb_great_circle_distance.sv
